// ===== rtl/bgc_pkg.sv =====
`timescale 1ns / 1ps

package bgc_pkg;

  // Log memory size; addresses wrap modulo this depth.
  localparam int unsigned LOG_DEPTH = 256;
  localparam int unsigned LOG_AW    = $clog2(LOG_DEPTH);
  localparam int unsigned ADDR_W    = 8;
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned ADC_W     = 10;
  localparam int unsigned CFG_W     = 10;
  localparam int unsigned BEATS     = 4;

  // Stream widths.
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 24;

  // Register reset values and clock limits.
  localparam logic [7:0]       PRESCALE_RST  = 8'd125;
  localparam logic [ADC_W-1:0] DOWN_THR_RST  = 10'd768;
  localparam logic [ADC_W-1:0] UP_THR_RST    = 10'd511;
  localparam logic [5:0]       SEC_LAST      = 6'd59;
  localparam logic [5:0]       MIN_LAST      = 6'd59;
  localparam logic [4:0]       HOUR_LAST     = 5'd23;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_BUTTON = 2'd1,
    OP_IR     = 2'd2,
    OP_ADC    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_PRESCALE = 2'd0,
    REG_DOWN_THR = 2'd1,
    REG_UP_THR   = 2'd2
  } reg_e;

  // Everything the output stage needs to play out the beats of one event.
  typedef struct packed {
    logic                          motor_raise;
    logic                          motor_lower;
    logic                          log_write;
    logic [BEATS-1:0][ADDR_W-1:0]  log_address;
    logic [BEATS-1:0][DATA_W-1:0]  log_data;
  } res_t;

  // Next log address, wrapping at the log depth.
  function automatic logic [LOG_AW-1:0] next_ptr(input logic [LOG_AW-1:0] a);
    logic [LOG_AW-1:0] r;
    if (a == LOG_AW'(LOG_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = a + 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/barrier_gate_controller_core.sv =====
`timescale 1ns / 1ps
// Parking barrier controller core.
// The slave stream carries one event per beat: tuser holds the event kind
// (timer tick, button, IR edge, ADC sample) and tdata the ADC code. The
// master stream returns result beats: motor raise/lower state, a log write
// flag with byte address and data, and tlast on the final beat of an event.
// A button press while the barrier is down yields four log beats (car count,
// hours, minutes, seconds); every other event yields a single beat.
// An accepted event passes through the input register, then the result register,
// before its first result beat is valid. Throughput is one event per cycle for
// single-beat events while the receiver does not stall; a logging button holds
// the result register for its four log beats, and that register sets the rate.
// The input register keeps taking a new event while the result register is
// still waiting on the receiver; when the receiver stalls, backpressure reaches
// s_axis_tready once both registers are full.
// The configuration port writes one register per cycle with cfg_we_i; the user
// must use it only while the block is idle, as the block does not enforce this.
// Reset clears the clock, car count and log pointer, marks the barrier down
// and stops the motor; no beats are pending after reset.

module barrier_gate_controller_core import bgc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [9:0] adc_value
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,  // [1:0] operation
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [0] motor_raise, [1] motor_lower, [2] log_write, [10:3] log_address,
  // [18:11] log_data
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_index_i,
  input  logic [CFG_W-1:0]       cfg_data_i
);

  logic             in_valid_q;
  op_e              in_op_q;
  logic [ADC_W-1:0] in_adc_q;
  logic             res_valid_q;
  res_t             res_q;
  res_t             res_d;
  logic [1:0]       beat_q;
  logic             last_beat;
  logic             res_free;
  logic             fire;

  // Result register frees when its final beat leaves.
  assign last_beat     = !res_q.log_write || (beat_q == 2'(BEATS - 1));
  assign res_free      = !res_valid_q || (m_axis_tready && last_beat);
  assign fire          = in_valid_q && res_free;
  assign s_axis_tready = !in_valid_q || fire;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q  <= op_e'(s_axis_tuser[1:0]);
      in_adc_q <= s_axis_tdata[ADC_W-1:0];
    end
  end

  bgc_event u_event (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .op_i        (in_op_q),
    .adc_i       (in_adc_q),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .res_o       (res_d)
  );

  // Result register and beat counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      beat_q      <= '0;
    end else if (res_free) begin
      res_valid_q <= fire;
      beat_q      <= '0;
    end else if (m_axis_tready) begin
      beat_q <= beat_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  // Output beat selection.
  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tlast  = last_beat;
  assign m_axis_tdata  = {5'b0, res_q.log_data[beat_q], res_q.log_address[beat_q],
                          res_q.log_write, res_q.motor_lower, res_q.motor_raise};

endmodule

// ===== rtl/bgc_event.sv =====
`timescale 1ns / 1ps

module bgc_event import bgc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  op_e               op_i,
  input  logic [ADC_W-1:0]  adc_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  output res_t              res_o
);

  logic [7:0]        prescale_term_q;
  logic [ADC_W-1:0]  down_thr_q, up_thr_q;
  logic [7:0]        presc_q, presc_d;
  logic [5:0]        sec_q, sec_d;
  logic [5:0]        min_q, min_d;
  logic [4:0]        hour_q, hour_d;
  logic [7:0]        car_q, car_d;
  logic [LOG_AW-1:0] ptr_q, ptr_d;
  logic              raising_q, raising_d;
  logic              lowering_q, lowering_d;
  logic              at_down_q, at_down_d;
  logic              at_up_q, at_up_d;
  logic              logging;
  logic [BEATS-1:0][LOG_AW-1:0] addr;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_term_q <= PRESCALE_RST;
      down_thr_q      <= DOWN_THR_RST;
      up_thr_q        <= UP_THR_RST;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_index_i))
        REG_PRESCALE: prescale_term_q <= cfg_data_i[7:0];
        REG_DOWN_THR: down_thr_q      <= cfg_data_i;
        REG_UP_THR:   up_thr_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Log addresses for a button event, starting at the write pointer.
  assign addr[0] = ptr_q;
  assign addr[1] = next_ptr(addr[0]);
  assign addr[2] = next_ptr(addr[1]);
  assign addr[3] = next_ptr(addr[2]);

  assign logging = (op_i == OP_BUTTON) && at_down_q;

  // Event decode and next state.
  always_comb begin
    presc_d    = presc_q;
    sec_d      = sec_q;
    min_d      = min_q;
    hour_d     = hour_q;
    car_d      = car_q;
    ptr_d      = ptr_q;
    raising_d  = raising_q;
    lowering_d = lowering_q;
    at_down_d  = at_down_q;
    at_up_d    = at_up_q;
    case (op_i)
      OP_TICK: begin
        if (presc_q == prescale_term_q) begin
          presc_d = '0;
          if (sec_q == SEC_LAST) begin
            sec_d = '0;
            if (min_q == MIN_LAST) begin
              min_d  = '0;
              hour_d = (hour_q == HOUR_LAST) ? '0 : hour_q + 1'b1;
            end else begin
              min_d = min_q + 1'b1;
            end
          end else begin
            sec_d = sec_q + 1'b1;
          end
        end else begin
          presc_d = presc_q + 1'b1;
        end
      end
      OP_BUTTON: begin
        if (at_down_q) begin
          car_d      = car_q + 1'b1;
          raising_d  = 1'b1;
          lowering_d = 1'b0;
          ptr_d      = next_ptr(addr[3]);
        end
      end
      OP_IR: begin
        if (at_up_q) begin
          raising_d  = 1'b0;
          lowering_d = 1'b1;
        end
      end
      OP_ADC: begin
        at_down_d = adc_i >= down_thr_q;
        at_up_d   = adc_i <= up_thr_q;
        if (lowering_q && at_down_d) begin
          lowering_d = 1'b0;
        end
        if (raising_q && at_up_d) begin
          raising_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Result record; log fields read zero unless a log write happens.
  always_comb begin
    res_o.motor_raise = raising_d;
    res_o.motor_lower = lowering_d;
    res_o.log_write   = logging;
    res_o.log_address = '0;
    res_o.log_data    = '0;
    if (logging) begin
      for (int i = 0; i < BEATS; i++) begin
        res_o.log_address[i] = ADDR_W'(addr[i]);
      end
      res_o.log_data[0] = car_q;
      res_o.log_data[1] = DATA_W'(hour_q);
      res_o.log_data[2] = DATA_W'(min_q);
      res_o.log_data[3] = DATA_W'(sec_q);
    end
  end

  // State registers, updated once per processed event.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      presc_q    <= '0;
      sec_q      <= '0;
      min_q      <= '0;
      hour_q     <= '0;
      car_q      <= '0;
      ptr_q      <= '0;
      raising_q  <= 1'b0;
      lowering_q <= 1'b0;
      at_down_q  <= 1'b1;
      at_up_q    <= 1'b0;
    end else if (fire_i) begin
      presc_q    <= presc_d;
      sec_q      <= sec_d;
      min_q      <= min_d;
      hour_q     <= hour_d;
      car_q      <= car_d;
      ptr_q      <= ptr_d;
      raising_q  <= raising_d;
      lowering_q <= lowering_d;
      at_down_q  <= at_down_d;
      at_up_q    <= at_up_d;
    end
  end

endmodule

// ===== rtl/bgc_checker.sv =====
`timescale 1ns / 1ps

module bgc_checker import bgc_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast
);

  // A stalled result beat holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled result beat changed");

  // A beat without a log write is always the only beat of its event.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tlast)
    else $error("non-log beat without tlast");

  // The motor never drives both ways.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("motor raise and lower both set");

  // Log beats of one event follow at once on consecutive wrapping addresses.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tdata[2] && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tdata[2] &&
      (m_axis_tdata[10:3] == (($past(m_axis_tdata[10:3]) == ADDR_W'(LOG_DEPTH - 1)) ?
        8'd0 : $past(m_axis_tdata[10:3]) + 8'd1)))
    else $error("log address sequence broken");

endmodule

bind barrier_gate_controller_core bgc_checker u_bgc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
